FILE: rtl/lps_pkg.sv
// Shared types and constants of the line pixel stepper.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int COORD_BITS = 10;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 8;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [ERR_BITS-1:0]   t_err;
    typedef logic [COLOR_BITS-1:0] t_color;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } t_dir;

    typedef struct packed {
        t_req_type req_type;
        t_coord    x_start;
        t_coord    y_start;
        t_coord    x_end;
        t_coord    y_end;
        t_color    pen_color;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_pixel;

    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_err   err_acc;
        t_coord abs_dx;
        t_coord abs_dy;
        t_dir   x_dir;
        t_dir   y_dir;
        logic   x_major;
        t_coord steps_left;
        t_color line_color;
        logic   busy;
    } t_state;

endpackage

FILE: rtl/lps_if.sv
// Valid/ready channel interfaces for line requests and emitted pixels.
`timescale 1ns / 1ps

interface lps_req_if;
    import lps_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lps_pix_if;
    import lps_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lps_step.sv
// Next-state and pixel logic for one request of the line stepper.
`timescale 1ns / 1ps

module lps_step (
    input  lps_pkg::t_req   i_req,
    input  lps_pkg::t_state i_state,
    output lps_pkg::t_state o_state,
    output logic            o_emit,
    output lps_pkg::t_pixel o_pixel
);
    import lps_pkg::*;

    t_coord w_adx;
    t_coord w_ady;
    logic   w_x_major;
    t_coord w_start_major;
    t_coord w_major;
    t_coord w_minor;
    t_err   w_sum;
    logic   w_minor_step;
    t_err   w_err;

    function automatic t_coord apply_dir(input t_coord c, input t_dir dir);
        t_coord r;
        unique case (dir)
            DIR_PLUS:  r = c + t_coord'(1);
            DIR_MINUS: r = c - t_coord'(1);
            default:   r = c;
        endcase
        return r;
    endfunction

    // Start path: absolute deltas and the major axis.
    assign w_adx = (i_req.x_end >= i_req.x_start) ? i_req.x_end - i_req.x_start
                                                  : i_req.x_start - i_req.x_end;
    assign w_ady = (i_req.y_end >= i_req.y_start) ? i_req.y_end - i_req.y_start
                                                  : i_req.y_start - i_req.y_end;
    assign w_x_major     = (w_adx >= w_ady);
    assign w_start_major = w_x_major ? w_adx : w_ady;

    // Advance path: one add, compare and subtract on the error term.
    assign w_major      = i_state.x_major ? i_state.abs_dx : i_state.abs_dy;
    assign w_minor      = i_state.x_major ? i_state.abs_dy : i_state.abs_dx;
    assign w_sum        = i_state.err_acc + t_err'(w_minor);
    assign w_minor_step = (w_sum >= t_err'(w_major));
    assign w_err        = w_minor_step ? w_sum - t_err'(w_major) : w_sum;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        if (i_req.req_type == REQ_START) begin
            o_emit             = 1'b1;
            o_state.cur_x      = i_req.x_start;
            o_state.cur_y      = i_req.y_start;
            o_state.abs_dx     = w_adx;
            o_state.abs_dy     = w_ady;
            o_state.line_color = i_req.pen_color;
            o_state.x_major    = w_x_major;
            o_state.err_acc    = t_err'(w_start_major >> 1);
            o_state.steps_left = w_start_major;
            o_state.busy       = (w_start_major != '0);
            if (i_req.x_end > i_req.x_start) begin
                o_state.x_dir = DIR_PLUS;
            end else if (i_req.x_end < i_req.x_start) begin
                o_state.x_dir = DIR_MINUS;
            end else begin
                o_state.x_dir = DIR_NONE;
            end
            if (i_req.y_end > i_req.y_start) begin
                o_state.y_dir = DIR_PLUS;
            end else if (i_req.y_end < i_req.y_start) begin
                o_state.y_dir = DIR_MINUS;
            end else begin
                o_state.y_dir = DIR_NONE;
            end
        end else if (i_state.busy) begin
            o_emit          = 1'b1;
            o_state.err_acc = w_err;
            if (i_state.x_major) begin
                o_state.cur_x = apply_dir(i_state.cur_x, i_state.x_dir);
                if (w_minor_step) begin
                    o_state.cur_y = apply_dir(i_state.cur_y, i_state.y_dir);
                end
            end else begin
                o_state.cur_y = apply_dir(i_state.cur_y, i_state.y_dir);
                if (w_minor_step) begin
                    o_state.cur_x = apply_dir(i_state.cur_x, i_state.x_dir);
                end
            end
            o_state.steps_left = i_state.steps_left - t_coord'(1);
            o_state.busy       = (o_state.steps_left != '0);
        end
    end

    assign o_pixel.pixel_x     = o_state.cur_x;
    assign o_pixel.pixel_y     = o_state.cur_y;
    assign o_pixel.pixel_color = o_state.line_color;
    assign o_pixel.last_pixel  = (o_state.steps_left == '0);

endmodule

FILE: rtl/line_pixel_stepper.sv
// Top level of the Bresenham line pixel stepper.
`timescale 1ns / 1ps

// A start request gives the first pixel of a line and an advance request gives
// the next one; an advance while no line is running is taken and gives nothing,
// and a start during a line drops it. The pixel of a request is in the output
// register the cycle after the request is taken, and a new request is taken
// every cycle while that register is empty or being drained. This rate rests
// on the update of the line state register by one add, compare and subtract
// on the error term.
module line_pixel_stepper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_req_if.sink   i_req,
    lps_pix_if.source o_pix
);
    import lps_pkg::*;

    t_state r_state;
    t_state n_state;
    t_pixel r_pix;
    t_pixel n_pix;
    logic   r_out_valid;
    logic   w_emit;
    logic   w_accept;

    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    lps_step u_step (
        .i_req   (i_req.data),
        .i_state (r_state),
        .o_state (n_state),
        .o_emit  (w_emit),
        .o_pixel (n_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_pix;

    // A running line always has pixels left, and an idle one has none.
    a_busy_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.busy == (r_state.steps_left != '0))
        else $error("busy flag disagrees with remaining step count");

    // The error term stays below the major delta while a line runs.
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.busy |-> (r_state.err_acc <
            t_err'(r_state.x_major ? r_state.abs_dx : r_state.abs_dy)))
        else $error("error accumulator reached the major delta");

    // A start request always shows its start point in the next cycle.
    a_start_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.data.req_type == REQ_START) |=>
            (r_out_valid && r_pix.pixel_x == $past(i_req.data.x_start)
             && r_pix.pixel_y == $past(i_req.data.y_start)))
        else $error("start request did not emit its start pixel");

    // An advance with no line running leaves the output empty.
    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.data.req_type == REQ_ADVANCE && !r_state.busy)
            |=> !r_out_valid)
        else $error("advance while idle produced a pixel");

    // Once the last pixel is out, no line is running.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pix.last_pixel) |-> !r_state.busy)
        else $error("last pixel emitted while line still running");

endmodule
